// ----- src/rcfb_pkg.sv -----
// Shared constants, hop table and types for the RC frame builder and hopper.
package rcfb_pkg;

  localparam int unsigned ChanMaxDefault = 10000;
  localparam int unsigned FrameLen       = 21;
  localparam int unsigned NumSticks      = 4;
  localparam int unsigned IdxW           = 5;
  localparam int unsigned CfgIdxW        = 3;
  // |stick| * 0x1f1 stays below 2^24 for any 16-bit stick value
  localparam int unsigned MagProdW       = 24;

  localparam logic [IdxW-1:0] LastByteIdx = IdxW'(FrameLen - 1);

  // operation codes
  localparam logic OpStart = 1'b0;
  localparam logic OpTick  = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTxId       = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdFixed    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgChansInUse = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBindFrames = 3'd3;

  localparam logic [3:0]  ChansInUseRst = 4'd8;
  localparam logic [15:0] BindFramesRst = 16'd2500;

  localparam logic [7:0] HdrBind    = 8'hAA;
  localparam logic [7:0] HdrNormal  = 8'h55;
  localparam logic [7:0] BindRfChan = 8'd1;

  localparam logic [8:0]  StickGain = 9'h1f1;
  localparam logic [15:0] ChanBase [NumSticks] = '{16'h05dc, 16'h05f4, 16'h03e8, 16'h05dc};

  // switch bits: aux_4 and aux_7 land in byte 12, aux_5 and aux_6 in byte 10
  localparam logic [7:0] SwAux4 = 8'h20;
  localparam logic [7:0] SwAux5 = 8'h40;
  localparam logic [7:0] SwAux6 = 8'h80;
  localparam logic [7:0] SwAux7 = 8'h10;

  localparam logic [7:0] HopTable [16][16] = '{
    '{8'h0a,8'h5a,8'h14,8'h64,8'h1e,8'h6e,8'h28,8'h78,
      8'h32,8'h82,8'h3c,8'h8c,8'h46,8'h96,8'h50,8'ha0},
    '{8'ha0,8'h50,8'h96,8'h46,8'h8c,8'h3c,8'h82,8'h32,
      8'h78,8'h28,8'h6e,8'h1e,8'h64,8'h14,8'h5a,8'h0a},
    '{8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,8'h46,8'h96,
      8'h1e,8'h6e,8'h3c,8'h8c,8'h28,8'h78,8'h32,8'h82},
    '{8'h82,8'h32,8'h78,8'h28,8'h8c,8'h3c,8'h6e,8'h1e,
      8'h96,8'h46,8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a},
    '{8'h28,8'h78,8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,
      8'h1e,8'h6e,8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96},
    '{8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,8'h6e,8'h1e,
      8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a,8'h78,8'h28},
    '{8'h50,8'ha0,8'h28,8'h78,8'h0a,8'h5a,8'h1e,8'h6e,
      8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96,8'h14,8'h64},
    '{8'h64,8'h14,8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,
      8'h6e,8'h1e,8'h5a,8'h0a,8'h78,8'h28,8'ha0,8'h50},
    '{8'h50,8'ha0,8'h46,8'h96,8'h3c,8'h8c,8'h28,8'h78,
      8'h0a,8'h5a,8'h32,8'h82,8'h1e,8'h6e,8'h14,8'h64},
    '{8'h64,8'h14,8'h6e,8'h1e,8'h82,8'h32,8'h5a,8'h0a,
      8'h78,8'h28,8'h8c,8'h3c,8'h96,8'h46,8'ha0,8'h50},
    '{8'h46,8'h96,8'h3c,8'h8c,8'h50,8'ha0,8'h28,8'h78,
      8'h0a,8'h5a,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64},
    '{8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h5a,8'h0a,
      8'h78,8'h28,8'ha0,8'h50,8'h8c,8'h3c,8'h96,8'h46},
    '{8'h46,8'h96,8'h0a,8'h5a,8'h3c,8'h8c,8'h14,8'h64,
      8'h50,8'ha0,8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82},
    '{8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,8'ha0,8'h50,
      8'h64,8'h14,8'h8c,8'h3c,8'h5a,8'h0a,8'h96,8'h46},
    '{8'h46,8'h96,8'h0a,8'h5a,8'h50,8'ha0,8'h3c,8'h8c,
      8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64},
    '{8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,
      8'h8c,8'h3c,8'ha0,8'h50,8'h5a,8'h0a,8'h96,8'h46}
  };

  function automatic logic [7:0] hop_lookup(logic [3:0] row, logic [3:0] col);
    return HopTable[row][col];
  endfunction

  typedef struct packed {
    logic       is_bind;
    logic [7:0] rf;
    logic       refresh;
  } hop_info_t;

  typedef struct packed {
    logic adv_s1;
    logic adv_s2;
    logic adv_s3;
  } pipe_adv_t;

  // sideband that travels with a tick through the scaling stages
  typedef struct packed {
    hop_info_t  hop;
    logic [3:0] sw;
  } side_t;

  typedef struct packed {
    hop_info_t                   hop;
    logic [3:0]                  sw;
    logic [NumSticks-1:0][15:0]  chan;
  } frame_t;

endpackage

// ----- src/rcfb_if.sv -----
// Handshake interfaces for the input, result and configuration channels.
interface rcfb_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic               bind_request;
  logic signed [15:0] stick_0;
  logic signed [15:0] stick_1;
  logic signed [15:0] stick_2;
  logic signed [15:0] stick_3;
  logic signed [15:0] aux_4;
  logic signed [15:0] aux_5;
  logic signed [15:0] aux_6;
  logic signed [15:0] aux_7;

  modport source (
    output valid, operation, bind_request, stick_0, stick_1, stick_2, stick_3,
           aux_4, aux_5, aux_6, aux_7,
    input  ready
  );
  modport sink (
    input  valid, operation, bind_request, stick_0, stick_1, stick_2, stick_3,
           aux_4, aux_5, aux_6, aux_7,
    output ready
  );
endinterface

interface rcfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [4:0] byte_index;
  logic [7:0] rf_channel;
  logic       bind_frame;
  logic       power_refresh;
  logic       last;

  modport source (
    output valid, data_byte, byte_index, rf_channel, bind_frame, power_refresh, last,
    input  ready
  );
  modport sink (
    input  valid, data_byte, byte_index, rf_channel, bind_frame, power_refresh, last,
    output ready
  );
endinterface

interface rcfb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/rc_frame_builder_hopper.sv -----
// Top level of the RC frame builder and channel hopper.
//
// Channels: in_i takes start and tick items, out_o gives frame bytes, cfg_i
// writes the four registers (tx_id, id_is_fixed, channels_in_use, bind_frames)
// and is always ready. Write the registers only while no item is in flight.
// A start item loads the hop row, offset and bind countdown in the cycle it is
// accepted and gives no output. A tick item gives 21 bytes, one per cycle while
// out_o is ready, each tagged with its index, the RF channel, the bind flag and
// the column-wrap flag; last marks byte 20.
// Path: a tick passes the input register, three scaling stages and the frame
// register before its first byte shows on out_o.
// Frames leave back to back through the byte-wide output port; the scaling
// pipeline holds up to four more ticks behind the frame on the wire, so in_i
// takes up to four ticks back to back while a frame waits or drains.
// A receiver stall holds the current byte and backs the pipeline up; in_i.ready
// drops only once all stages are full.
// Reset clears the hop state, the bind countdown and all valid flags and loads
// the register defaults; no clearing pass is needed.
module rc_frame_builder_hopper #(
  parameter int unsigned CHAN_MAX = rcfb_pkg::ChanMaxDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rcfb_in_if.sink    in_i,
  rcfb_out_if.source out_o,
  rcfb_cfg_if.sink   cfg_i
);

  // configuration registers
  logic [31:0] tx_id_q;
  logic        id_fixed_q;
  logic [3:0]  chans_q;
  logic [15:0] bind_frames_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_id_q       <= 32'd0;
      id_fixed_q    <= 1'b0;
      chans_q       <= rcfb_pkg::ChansInUseRst;
      bind_frames_q <= rcfb_pkg::BindFramesRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        rcfb_pkg::CfgTxId:       tx_id_q       <= cfg_i.data;
        rcfb_pkg::CfgIdFixed:    id_fixed_q    <= cfg_i.data[0];
        rcfb_pkg::CfgChansInUse: chans_q       <= cfg_i.data[3:0];
        rcfb_pkg::CfgBindFrames: bind_frames_q <= cfg_i.data[15:0];
        default: ;  // drop writes outside the register list
      endcase
    end
  end

  // pipeline control: each stage advances when it is empty or its successor moves
  logic in_fire;
  logic s0_valid_q, s1_valid_q, s2_valid_q, s3_valid_q;
  logic s0_ready, s1_ready, s2_ready, s3_ready, f_ready;
  logic f_load;
  rcfb_pkg::pipe_adv_t adv;

  assign s3_ready = !s3_valid_q || f_ready;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s0_ready = !s0_valid_q || s1_ready;
  assign f_load   = s3_valid_q && f_ready;

  assign in_i.ready = s0_ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign adv.adv_s1 = s1_ready;
  assign adv.adv_s2 = s2_ready;
  assign adv.adv_s3 = s3_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      // start items stop at the hop state and leave a bubble
      if (s0_ready) s0_valid_q <= in_fire && (in_i.operation == rcfb_pkg::OpTick);
      if (s1_ready) s1_valid_q <= s0_valid_q;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // hop state: a tick takes its RF channel and flags at acceptance
  rcfb_pkg::hop_info_t hop_now;

  rcfb_hop_ctrl u_hop_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .op_i          (in_i.operation),
    .bind_req_i    (in_i.bind_request),
    .tx_id_lo_i    (tx_id_q[7:0]),
    .id_fixed_i    (id_fixed_q),
    .bind_frames_i (bind_frames_q),
    .hop_o         (hop_now)
  );

  // input register
  logic [rcfb_pkg::NumSticks-1:0][15:0] in_sticks;
  logic [rcfb_pkg::NumSticks-1:0][15:0] s0_stick_q;
  logic [3:0]                           in_sw;
  rcfb_pkg::side_t                      s0_side_d, s0_side_q, s1_side_q, s2_side_q, s3_side_q;

  assign in_sticks = {in_i.stick_3, in_i.stick_2, in_i.stick_1, in_i.stick_0};
  // a switch counts as on when strictly positive
  assign in_sw[0] = !in_i.aux_4[15] && (in_i.aux_4 != 16'sd0);
  assign in_sw[1] = !in_i.aux_5[15] && (in_i.aux_5 != 16'sd0);
  assign in_sw[2] = !in_i.aux_6[15] && (in_i.aux_6 != 16'sd0);
  assign in_sw[3] = !in_i.aux_7[15] && (in_i.aux_7 != 16'sd0);

  assign s0_side_d.hop = hop_now;
  assign s0_side_d.sw  = in_sw;

  always_ff @(posedge clk_i) begin
    if (s0_ready) begin
      s0_stick_q <= in_sticks;
      s0_side_q  <= s0_side_d;
    end
    if (s1_ready) s1_side_q <= s0_side_q;
    if (s2_ready) s2_side_q <= s1_side_q;
    if (s3_ready) s3_side_q <= s2_side_q;
  end

  // scaling lanes, one per stick
  logic [rcfb_pkg::NumSticks-1:0][15:0] scaled;
  logic [rcfb_pkg::NumSticks-1:0][15:0] masked;

  for (genvar i = 0; i < rcfb_pkg::NumSticks; i++) begin : g_lane
    rcfb_chan_scale #(
      .CHAN_MAX (CHAN_MAX),
      .Base     (rcfb_pkg::ChanBase[i])
    ) u_scale (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .stick_i (s0_stick_q[i]),
      .value_o (scaled[i])
    );
    // indices above channels_in_use send zero
    assign masked[i] = (4'(i) <= chans_q) ? scaled[i] : 16'd0;
  end

  rcfb_pkg::frame_t frame_d;

  always_comb begin
    frame_d.hop  = s3_side_q.hop;
    frame_d.sw   = s3_side_q.sw;
    frame_d.chan = masked;
  end

  rcfb_serializer u_serializer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (f_load),
    .frame_i (frame_d),
    .tx_id_i (tx_id_q),
    .ready_o (f_ready),
    .out_o   (out_o)
  );

  // bind frames ride the fixed bind channel and never flag a column wrap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bind_frame |->
      (out_o.rf_channel == rcfb_pkg::BindRfChan) && !out_o.power_refresh)
    else $error("bind frame on wrong channel or with refresh");

  // within a frame the next byte follows directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last |=>
      out_o.valid && (out_o.byte_index == $past(out_o.byte_index) + 5'd1))
    else $error("frame byte sequence broken");

  // input backs up only when every stage holds a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |->
      s0_valid_q && s1_valid_q && s2_valid_q && s3_valid_q && out_o.valid)
    else $error("input stalled with a free stage");

endmodule

// ----- src/rcfb_hop_ctrl.sv -----
// Hop row, column, offset and bind countdown state, updated once per accepted item.
module rcfb_hop_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic                  op_i,
  input  logic                  bind_req_i,
  input  logic [7:0]            tx_id_lo_i,
  input  logic                  id_fixed_i,
  input  logic [15:0]           bind_frames_i,
  output rcfb_pkg::hop_info_t   hop_o
);

  logic [3:0]  row_q, row_d;
  logic [3:0]  col_q, col_d;
  logic [3:0]  offset_q, offset_d;
  logic [15:0] bind_left_q, bind_left_d;
  logic        is_bind;

  assign is_bind = bind_left_q != 16'd0;

  always_comb begin
    hop_o.is_bind = is_bind;
    hop_o.rf      = is_bind ? rcfb_pkg::BindRfChan
                            : rcfb_pkg::hop_lookup(row_q, col_q) - {4'd0, offset_q};
    // column wraps to zero after this frame
    hop_o.refresh = !is_bind && (col_q == 4'hf);

    row_d       = row_q;
    col_d       = col_q;
    offset_d    = offset_q;
    bind_left_d = bind_left_q;
    if (fire_i) begin
      if (op_i == rcfb_pkg::OpStart) begin
        row_d       = tx_id_lo_i[3:0];
        col_d       = 4'd0;
        offset_d    = tx_id_lo_i[7:4];
        bind_left_d = (bind_req_i || !id_fixed_i) ? bind_frames_i : 16'd0;
      end else if (is_bind) begin
        bind_left_d = bind_left_q - 16'd1;
      end else begin
        col_d = col_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= 4'd0;
      col_q       <= 4'd0;
      offset_q    <= 4'd0;
      bind_left_q <= 16'd0;
    end else begin
      row_q       <= row_d;
      col_q       <= col_d;
      offset_q    <= offset_d;
      bind_left_q <= bind_left_d;
    end
  end

endmodule

// ----- src/rcfb_chan_scale.sv -----
// One stick channel: scale by 0x1f1/CHAN_MAX toward zero, add base, clamp at zero.
module rcfb_chan_scale #(
  parameter int unsigned CHAN_MAX = rcfb_pkg::ChanMaxDefault,
  parameter logic [15:0] Base     = 16'h05dc
) (
  input  logic                 clk_i,
  input  rcfb_pkg::pipe_adv_t  adv_i,
  input  logic signed [15:0]   stick_i,
  output logic [15:0]          value_o
);

  localparam int unsigned XW = rcfb_pkg::MagProdW;
  localparam int unsigned Sh = XW;
  localparam int unsigned MW = Sh + 1;
  localparam int unsigned VW = XW + 2;
  // floor(2^Sh / CHAN_MAX): the estimate is the quotient or one below it
  localparam logic [MW-1:0] Recip   = MW'((64'd1 << Sh) / 64'(CHAN_MAX));
  localparam logic [XW-1:0] Divisor = XW'(CHAN_MAX);

  logic [15:0]        mag;
  logic [XW-1:0]      x_s1_d, x_s1_q, x_s2_q, x_s3_q;
  logic               neg_s1_q, neg_s2_q, neg_s3_q;
  logic [XW+MW-1:0]   recip_prod;
  logic [XW-1:0]      q0_s2_q, q0_s3_q;
  logic [2*XW-1:0]    back_prod;
  logic [XW-1:0]      pc_s3_q;
  logic [XW-1:0]      rem;
  logic [XW-1:0]      quot;
  logic signed [VW-1:0] mag_v, signed_v, sum_v;

  assign mag        = stick_i[15] ? (~$unsigned(stick_i) + 16'd1) : $unsigned(stick_i);
  assign x_s1_d     = XW'({9'd0, mag} * {16'd0, rcfb_pkg::StickGain});
  assign recip_prod = (XW+MW)'(x_s1_q) * (XW+MW)'(Recip);
  assign back_prod  = (2*XW)'(q0_s2_q) * (2*XW)'(Divisor);

  always_ff @(posedge clk_i) begin
    if (adv_i.adv_s1) begin
      x_s1_q   <= x_s1_d;
      neg_s1_q <= stick_i[15];
    end
    if (adv_i.adv_s2) begin
      x_s2_q   <= x_s1_q;
      q0_s2_q  <= recip_prod[Sh +: XW];
      neg_s2_q <= neg_s1_q;
    end
    if (adv_i.adv_s3) begin
      x_s3_q   <= x_s2_q;
      q0_s3_q  <= q0_s2_q;
      pc_s3_q  <= back_prod[XW-1:0];
      neg_s3_q <= neg_s2_q;
    end
  end

  // correct the estimate by one where the remainder reaches the divisor
  assign rem      = x_s3_q - pc_s3_q;
  assign quot     = q0_s3_q + XW'(rem >= Divisor);
  assign mag_v    = $signed({2'b00, quot});
  assign signed_v = neg_s3_q ? -mag_v : mag_v;
  assign sum_v    = signed_v + $signed({{(VW-16){1'b0}}, Base});
  assign value_o  = sum_v[VW-1] ? 16'd0 : sum_v[15:0];

endmodule

// ----- src/rcfb_serializer.sv -----
// Frame register and byte counter that send one 21-byte frame a byte at a time.
module rcfb_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rcfb_pkg::frame_t  frame_i,
  input  logic [31:0]       tx_id_i,
  output logic              ready_o,
  rcfb_out_if.source        out_o
);

  logic                      valid_q;
  logic [rcfb_pkg::IdxW-1:0] idx_q;
  rcfb_pkg::frame_t          frame_q;
  logic                      fire;
  logic                      last;
  logic [7:0]                byte_val;

  assign fire    = out_o.valid && out_o.ready;
  assign last    = idx_q == rcfb_pkg::LastByteIdx;
  assign ready_o = !valid_q || (fire && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load_i) begin
        valid_q <= 1'b1;
      end else if (fire && last) begin
        valid_q <= 1'b0;
      end
      if (fire) begin
        idx_q <= last ? '0 : idx_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end
  end

  always_comb begin
    case (idx_q)
      5'd0:    byte_val = frame_q.hop.is_bind ? rcfb_pkg::HdrBind : rcfb_pkg::HdrNormal;
      5'd1:    byte_val = tx_id_i[7:0];
      5'd2:    byte_val = tx_id_i[15:8];
      5'd3:    byte_val = tx_id_i[23:16];
      5'd4:    byte_val = tx_id_i[31:24];
      5'd5:    byte_val = frame_q.chan[0][7:0];
      5'd6:    byte_val = frame_q.chan[0][15:8];
      5'd7:    byte_val = frame_q.chan[1][7:0];
      5'd8:    byte_val = frame_q.chan[1][15:8];
      5'd9:    byte_val = frame_q.chan[2][7:0];
      5'd10:   byte_val = frame_q.chan[2][15:8]
                          | (frame_q.sw[1] ? rcfb_pkg::SwAux5 : 8'h00)
                          | (frame_q.sw[2] ? rcfb_pkg::SwAux6 : 8'h00);
      5'd11:   byte_val = frame_q.chan[3][7:0];
      5'd12:   byte_val = frame_q.chan[3][15:8]
                          | (frame_q.sw[0] ? rcfb_pkg::SwAux4 : 8'h00)
                          | (frame_q.sw[3] ? rcfb_pkg::SwAux7 : 8'h00);
      default: byte_val = 8'h00;
    endcase
  end

  assign out_o.valid         = valid_q;
  assign out_o.data_byte     = byte_val;
  assign out_o.byte_index    = idx_q;
  assign out_o.rf_channel    = frame_q.hop.rf;
  assign out_o.bind_frame    = frame_q.hop.is_bind;
  assign out_o.power_refresh = frame_q.hop.refresh;
  assign out_o.last          = last;

endmodule

// ----- tb/rcfb_checker.sv -----
// Scoreboard for the RC frame builder: tracks registers and hop state, predicts frame bytes.
module rcfb_checker #(
  parameter int unsigned CHAN_MAX = rcfb_pkg::ChanMaxDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  rcfb_in_if   in_i,
  rcfb_out_if  out_i,
  rcfb_cfg_if  cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic [4:0] idx;
    logic [7:0] rf;
    logic       is_bind;
    logic       refresh;
    logic       last;
  } frame_byte_t;

  frame_byte_t frame_bytes_q[$];

  logic [31:0] tx_id;
  logic        id_fixed;
  logic [3:0]  chans_in_use;
  logic [15:0] bind_frames;
  logic [3:0]  hop_row;
  logic [3:0]  hop_col;
  logic [3:0]  hop_offset;
  logic [15:0] bind_left;

  always @(posedge clk_i or negedge rst_ni) begin : track
    frame_byte_t        got;
    frame_byte_t        want;
    logic [7:0]         fb [rcfb_pkg::FrameLen];
    logic signed [15:0] sticks [4];
    logic [7:0]         rf;
    logic               binding;
    logic               refresh;
    int                 v;
    if (!rst_ni) begin
      tx_id        = '0;
      id_fixed     = 1'b0;
      chans_in_use = rcfb_pkg::ChansInUseRst;
      bind_frames  = rcfb_pkg::BindFramesRst;
      hop_row      = '0;
      hop_col      = '0;
      hop_offset   = '0;
      bind_left    = '0;
      frame_bytes_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got = '{data: out_i.data_byte, idx: out_i.byte_index, rf: out_i.rf_channel,
                is_bind: out_i.bind_frame, refresh: out_i.power_refresh, last: out_i.last};
        if (frame_bytes_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("[%0t] unexpected frame byte: data=%02h idx=%0d rf=%02h bind=%0b",
                     $realtime, got.data, got.idx, got.rf, got.is_bind);
        end else begin
          want = frame_bytes_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("[%0t] frame byte mismatch:", $realtime);
              $display("  expected data=%02h idx=%0d rf=%02h bind=%0b refresh=%0b last=%0b",
                       want.data, want.idx, want.rf, want.is_bind, want.refresh, want.last);
              $display("  actual   data=%02h idx=%0d rf=%02h bind=%0b refresh=%0b last=%0b",
                       got.data, got.idx, got.rf, got.is_bind, got.refresh, got.last);
            end
          end
        end
      end

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          rcfb_pkg::CfgTxId:       tx_id = cfg_i.data;
          rcfb_pkg::CfgIdFixed:    id_fixed = cfg_i.data[0];
          rcfb_pkg::CfgChansInUse: chans_in_use = cfg_i.data[3:0];
          rcfb_pkg::CfgBindFrames: bind_frames = cfg_i.data[15:0];
          default: ;
        endcase
      end

      if (in_i.valid && in_i.ready) begin
        if (in_i.operation == rcfb_pkg::OpStart) begin
          hop_row    = tx_id[3:0];
          hop_col    = '0;
          hop_offset = tx_id[7:4];
          bind_left  = (in_i.bind_request || !id_fixed) ? bind_frames : 16'd0;
        end else begin
          sticks[0] = in_i.stick_0;
          sticks[1] = in_i.stick_1;
          sticks[2] = in_i.stick_2;
          sticks[3] = in_i.stick_3;
          binding   = (bind_left != 16'd0);
          fb[0]     = binding ? rcfb_pkg::HdrBind : rcfb_pkg::HdrNormal;
          for (int b = 0; b < 4; b++) fb[1+b] = tx_id[8*b +: 8];
          // sticks are scaled and offset, the upper four channels carry zero
          for (int c = 0; c < 8; c++) begin
            v = 0;
            if (c < 4 && c <= int'(chans_in_use)) begin
              v = int'(sticks[c]) * int'(rcfb_pkg::StickGain) / int'(CHAN_MAX)
                  + int'(rcfb_pkg::ChanBase[c]);
              if (v < 0) v = 0;
            end
            fb[5+2*c] = v[7:0];
            fb[6+2*c] = v[15:8];
          end
          if (in_i.aux_4 > 0) fb[12] |= rcfb_pkg::SwAux4;
          if (in_i.aux_5 > 0) fb[10] |= rcfb_pkg::SwAux5;
          if (in_i.aux_6 > 0) fb[10] |= rcfb_pkg::SwAux6;
          if (in_i.aux_7 > 0) fb[12] |= rcfb_pkg::SwAux7;
          refresh = 1'b0;
          if (binding) begin
            rf        = rcfb_pkg::BindRfChan;
            bind_left = bind_left - 16'd1;
          end else begin
            rf      = rcfb_pkg::HopTable[hop_row][hop_col] - {4'd0, hop_offset};
            hop_col = hop_col + 4'd1;
            refresh = (hop_col == 4'd0);
          end
          for (int k = 0; k < rcfb_pkg::FrameLen; k++)
            frame_bytes_q.push_back('{data: fb[k], idx: 5'(k), rf: rf, is_bind: binding,
                                      refresh: refresh,
                                      last: (k == rcfb_pkg::FrameLen - 1)});
        end
      end
      pending_o = frame_bytes_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top: clock, reset, stimulus, receiver back-pressure, watchdog and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ChanMax = rcfb_pkg::ChanMaxDefault;
  localparam int WatchdogLimit = 3000;  // idle cycles; well above the long receiver hold
  localparam int RxHoldCycles  = 400;
  localparam int SettleCycles  = 8;     // first byte waits behind the input, scaling and frame registers
  localparam int DrainCycles   = 30;
  localparam int RandomPhases  = 12;
  localparam int PressurePhase = 5;

  typedef logic [7:0][15:0] stick_vec_t;  // [0..3] sticks, [4..7] aux switches

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;

  // sender pacing and the long receiver hold requested by the stimulus
  bit   rx_hold_req;
  bit   tx_no_gaps;
  bit   tx_steady;
  int   tx_burst_left;

  rcfb_in_if  in_if();
  rcfb_out_if out_if();
  rcfb_cfg_if cfg_if();

  rc_frame_builder_hopper #(.CHAN_MAX(ChanMax)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  rcfb_checker #(.CHAN_MAX(ChanMax)) u_frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic stick_vec_t uniform_sticks(logic [15:0] val);
    return {8{val}};
  endfunction

  // Mix full-scale corners, zero, +/-1 and fully random words.
  function automatic stick_vec_t random_sticks();
    stick_vec_t s;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 7))
        0:       s[i] = 16'h7fff;
        1:       s[i] = 16'h8000;
        2:       s[i] = 16'h0000;
        3:       s[i] = 16'h0001;
        4:       s[i] = 16'hffff;
        default: s[i] = 16'($urandom_range(0, 65535));
      endcase
    end
    return s;
  endfunction

  // Write one register; the channel is always ready but wait for it anyway.
  task automatic write_reg(input logic [rcfb_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_config(input logic [31:0] tx, input logic fixed,
                              input logic [3:0] chans, input logic [15:0] bframes);
    write_reg(rcfb_pkg::CfgTxId, tx);
    write_reg(rcfb_pkg::CfgIdFixed, {31'd0, fixed});
    write_reg(rcfb_pkg::CfgChansInUse, {28'd0, chans});
    write_reg(rcfb_pkg::CfgBindFrames, {16'd0, bframes});
  endtask

  // Offer one item after a random gap (none while steady or gapless); return at the edge that accepts it.
  task automatic send_item(input logic op, input logic bind_req, input stick_vec_t vals);
    int gap;
    if (tx_burst_left == 0) begin
      tx_steady     = ($urandom_range(0, 3) == 0);
      tx_burst_left = $urandom_range(4, 20);
    end
    tx_burst_left--;
    gap = (tx_steady || tx_no_gaps) ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    repeat (gap) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= op;
    in_if.bind_request <= bind_req;
    in_if.stick_0      <= vals[0];
    in_if.stick_1      <= vals[1];
    in_if.stick_2      <= vals[2];
    in_if.stick_3      <= vals[3];
    in_if.aux_4        <= vals[4];
    in_if.aux_5        <= vals[5];
    in_if.aux_6        <= vals[6];
    in_if.aux_7        <= vals[7];
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
  endtask

  // Drop valid and wait until every predicted byte has arrived, then let the pipe empty.
  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Receiver: after each byte hold ready low for a drawn number of cycles.
  initial begin : receiver
    int  stall;
    int  burst_left;
    bit  steady;
    bit  hold_done;
    stall        = 0;
    burst_left   = 0;
    steady       = 1'b0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (burst_left == 0) begin
          steady     = ($urandom_range(0, 3) == 0);
          burst_left = $urandom_range(10, 60);
        end
        burst_left--;
        stall = steady ? 0 : $urandom_range(0, 11);
      end
      // long hold so the pipeline backs up and in_i.ready drops
      if (rx_hold_req && !hold_done) begin
        stall     = RxHoldCycles;
        hold_done = 1'b1;
      end
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no channel moves an item for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int          n_items;
    logic [31:0] tx;
    logic [3:0]  chans;
    logic [15:0] bframes;
    rst_ni             = 1'b0;
    rx_hold_req        = 1'b0;
    tx_no_gaps         = 1'b0;
    tx_steady          = 1'b0;
    tx_burst_left      = 0;
    in_if.valid        = 1'b0;
    in_if.operation    = rcfb_pkg::OpTick;
    in_if.bind_request = 1'b0;
    in_if.stick_0      = '0;
    in_if.stick_1      = '0;
    in_if.stick_2      = '0;
    in_if.stick_3      = '0;
    in_if.aux_4        = '0;
    in_if.aux_5        = '0;
    in_if.aux_6        = '0;
    in_if.aux_7        = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = rcfb_pkg::CfgTxId;
    cfg_if.data        = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Ticks before any start: hop from row 0, offset 0, no binding.
    send_item(rcfb_pkg::OpTick, 1'b0, uniform_sticks(16'h7fff));
    send_item(rcfb_pkg::OpTick, 1'b0, uniform_sticks(16'h8000));

    // Bind request with a fixed id: three bind frames, then hopping resumes.
    settle();
    apply_config(32'hffff_ffff, 1'b1, 4'd8, 16'd3);
    send_item(rcfb_pkg::OpStart, 1'b1, uniform_sticks(16'h0000));
    send_item(rcfb_pkg::OpTick, 1'b0, uniform_sticks(16'h0000));
    send_item(rcfb_pkg::OpTick, 1'b0, uniform_sticks(16'hffff));
    send_item(rcfb_pkg::OpTick, 1'b0, uniform_sticks(16'h0001));
    send_item(rcfb_pkg::OpTick, 1'b0, {16'h0001, 16'h8000, 16'hffff, 16'h7fff,
                                       16'h8000, 16'h1234, 16'hedcc, 16'h7fff});
    // Fixed id and no request: no bind frames.
    send_item(rcfb_pkg::OpStart, 1'b0, uniform_sticks(16'hffff));
    send_item(rcfb_pkg::OpTick, 1'b0, {16'h7fff, 16'h0001, 16'h8000, 16'h0000,
                                       16'h7fff, 16'h8000, 16'h0000, 16'h5555});
    send_item(rcfb_pkg::OpTick, 1'b0, uniform_sticks(16'haaaa));

    // Id not fixed but zero bind frames; only stick channel 0 in use, switch bits still set.
    settle();
    apply_config(32'h0000_0000, 1'b0, 4'd0, 16'd0);
    send_item(rcfb_pkg::OpStart, 1'b0, uniform_sticks(16'h0000));
    send_item(rcfb_pkg::OpTick, 1'b0, {{4{16'h7fff}}, {4{16'h8000}}});
    send_item(rcfb_pkg::OpTick, 1'b0, {{4{16'h0001}}, {4{16'h7fff}}});

    // Channel count above eight with the longest bind countdown.
    settle();
    apply_config(32'h5a5a_00f3, 1'b0, 4'd15, 16'hffff);
    send_item(rcfb_pkg::OpStart, 1'b1, uniform_sticks(16'h7fff));
    send_item(rcfb_pkg::OpTick, 1'b0, uniform_sticks(16'h8000));
    send_item(rcfb_pkg::OpTick, 1'b0, uniform_sticks(16'h7fff));

    // New id after start: the frame carries it at once, the hop row waits for a start.
    settle();
    apply_config(32'h0000_00a7, 1'b1, 4'd2, 16'd5);
    send_item(rcfb_pkg::OpStart, 1'b0, uniform_sticks(16'h0000));
    send_item(rcfb_pkg::OpTick, 1'b0, random_sticks());
    settle();
    write_reg(rcfb_pkg::CfgTxId, 32'h8765_43f1);
    send_item(rcfb_pkg::OpTick, 1'b0, random_sticks());
    send_item(rcfb_pkg::OpTick, 1'b0, random_sticks());

    // Random sessions: fresh settings, a start, then mostly ticks with a stray restart.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      settle();
      case ($urandom_range(0, 3))
        0:       tx = 32'hffff_ffff;
        1:       tx = 32'h0000_0000;
        default: tx = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0:       chans = 4'd0;
        1:       chans = 4'd8;
        2:       chans = 4'd15;
        default: chans = 4'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 9))
        0:       bframes = 16'd0;
        1:       bframes = 16'hffff;
        default: bframes = 16'($urandom_range(1, 6));
      endcase
      apply_config(tx, 1'($urandom_range(0, 1)), chans, bframes);
      send_item(rcfb_pkg::OpStart, 1'($urandom_range(0, 1)), random_sticks());
      if (ph == PressurePhase) begin
        // Hold the receiver off while ticks keep coming back to back.
        tx_no_gaps  = 1'b1;
        rx_hold_req = 1'b1;
        repeat (12) send_item(rcfb_pkg::OpTick, 1'b0, random_sticks());
        tx_no_gaps  = 1'b0;
      end
      n_items = $urandom_range(18, 28);
      repeat (n_items) begin
        if ($urandom_range(0, 11) == 0)
          send_item(rcfb_pkg::OpStart, 1'($urandom_range(0, 1)), random_sticks());
        else
          send_item(rcfb_pkg::OpTick, 1'($urandom_range(0, 1)), random_sticks());
      end
    end

    settle();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
src/rcfb_pkg.sv
src/rcfb_if.sv
src/rcfb_hop_ctrl.sv
src/rcfb_chan_scale.sv
src/rcfb_serializer.sv
src/rc_frame_builder_hopper.sv
tb/rcfb_checker.sv
tb/tb.sv
